### hw/rtl/pba_pkg.sv
// Shared constants, command codes and register indexes of the page bitmap allocator.
package pba_pkg;

   // Default geometry of the map.
   localparam int DEF_PAGE_COUNT = 262144;
   localparam int DEF_WORD_BITS  = 64;

   // Fixed field widths.
   localparam int CMD_W     = 2;
   localparam int PAGE_W    = 18;
   localparam int CFG_W     = 19;
   localparam int CSR_IDX_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RANGE = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_MEMORY_PAGES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DMA_ZONE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_ZONE    = 2'd2;

   // Register reset values.
   localparam logic [CFG_W-1:0] RST_MEMORY_PAGES = 19'd262144;
   localparam logic [CFG_W-1:0] RST_DMA_ZONE     = 19'd4096;
   localparam logic [CFG_W-1:0] RST_HIGH_ZONE    = 19'd262144;

endpackage

### hw/rtl/pba_div.sv
// Divider by a constant divisor through a reciprocal multiply, with the result registered.
module pba_div #(
   parameter int NUM_W   = 20,
   parameter int DIVISOR = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [NUM_W-1:0]            dividend,
   output logic                        done,
   output logic [NUM_W-1:0]            quotient,
   output logic [$clog2(DIVISOR)-1:0]  remainder
);

   localparam int REM_W  = $clog2(DIVISOR);
   localparam int SH     = NUM_W + REM_W;
   localparam int RCP_W  = NUM_W + 1;
   localparam int PROD_W = NUM_W + RCP_W;

   // Rounded-up reciprocal; exact for every dividend below 2**NUM_W.
   localparam longint unsigned RECIP_L =
      ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
   localparam logic [RCP_W-1:0] RECIP = RCP_W'(RECIP_L);

   logic [PROD_W-1:0] prod;
   logic [NUM_W-1:0]  back;
   logic [NUM_W-1:0]  quot_ff, quot_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              done_ff;

   // Quotient from the high part of the product, remainder by subtracting back.
   always_comb begin
      prod    = PROD_W'(dividend) * PROD_W'(RECIP);
      quot_in = NUM_W'(prod >> SH);
      back    = quot_in * NUM_W'(DIVISOR);
      rem_in  = REM_W'(dividend - back);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= start;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

### hw/rtl/page_bitmap_allocator.sv
// Top level of the page bitmap allocator: command sequencer around the used-bit map memory.
//
// One used bit per page, WORD_BITS pages to a word of a single-port synchronous memory.
// After reset the block is busy while a clearing pass writes all MAP_WORDS words (4096
// by default) and so marks every page used. A command is taken when start is high and
// busy is low; its single result appears on the rsp_ ports for exactly one cycle with
// rsp_valid, and the receiver cannot stall it. Every command that touches the map first
// splits the page index into word and bit offset with a registered reciprocal multiply,
// then reads and writes the map word by word, through a read state and an evaluate state
// for each word, so the words touched set the time. A mark or query touches a single
// word and a range mark every word it covers; an allocation opens each zone window it
// searches, skips an empty one, scans a nonempty one word by word, and passes a fallback
// state for each fallback or the final failure. The result appears in the first cycle
// with busy low. A mark, query or range mark of a page outside the map answers in the
// next cycle without raising busy. Configuration writes are taken every cycle.
module page_bitmap_allocator #(
   parameter int PAGE_COUNT = pba_pkg::DEF_PAGE_COUNT,
   parameter int WORD_BITS  = pba_pkg::DEF_WORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // Command word.
   input  logic                          req_start,
   output logic                          busy,
   input  logic [pba_pkg::CMD_W-1:0]     req_cmd,
   input  logic [pba_pkg::PAGE_W-1:0]    req_page,
   input  logic [pba_pkg::CFG_W-1:0]     req_count,
   input  logic                          req_used,
   input  logic [pba_pkg::CFG_W-1:0]     req_limit_page,
   // Result word.
   output logic                          rsp_valid,
   output logic                          rsp_ok,
   output logic [pba_pkg::PAGE_W-1:0]    rsp_result_page,
   output logic                          rsp_was_used,
   // Register writes.
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pba_pkg::CFG_W-1:0]     csr_data
);

   localparam int MAP_WORDS = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
   localparam int MW_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W     = $clog2(WORD_BITS);
   localparam int PC_W      = $clog2(PAGE_COUNT + 1);
   localparam int PG_W      = ((PC_W > pba_pkg::CFG_W) ? PC_W : pba_pkg::CFG_W) + 1;

   localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] WORD_ONE  = WORD_BITS'(1);

   // Sequencer states.
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_WIN   = 3'd2;
   localparam logic [2:0] S_NEXT  = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_READ  = 3'd5;
   localparam logic [2:0] S_EVAL  = 3'd6;

   // Lowest set bit of a word.
   function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
      logic [OFF_W-1:0] pos;
      pos = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            pos = OFF_W'(i);
         end
      end
      return pos;
   endfunction

   logic [2:0]                  state_ff, state_in;
   logic [pba_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic                        used_ff, used_in;
   logic [PG_W-1:0]             start_ff, start_in;
   logic [PG_W-1:0]             lim_ff, lim_in;
   logic [PG_W-1:0]             win_end_ff, win_end_in;
   logic [PG_W-1:0]             base_ff, base_in;
   logic [MW_W-1:0]             word_ff, word_in;
   logic [OFF_W-1:0]            off_ff, off_in;
   logic                        first_ff, first_in;
   logic                        was_ff, was_in;
   logic [pba_pkg::CFG_W-1:0]   mem_pages_ff, dma_zone_ff, high_zone_ff;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [pba_pkg::PAGE_W-1:0]  rsp_page_ff, rsp_page_in;
   logic                        rsp_was_ff, rsp_was_in;

   logic [WORD_BITS-1:0]        map_mem [MAP_WORDS];
   logic [WORD_BITS-1:0]        rd_data_ff;
   logic                        mem_we;
   logic [WORD_BITS-1:0]        mem_wdata;

   logic                        div_start;
   logic [PG_W-1:0]             div_num;
   logic                        div_done;
   logic [PG_W-1:0]             div_quot;
   logic [OFF_W-1:0]            div_rem;

   logic [PG_W-1:0]             mp, dz, hz, limit, page_x, mem_end, ideal;
   logic [PG_W-1:0]             a_start, a_lim, range_end, eff_end;
   logic [PG_W-1:0]             next_base, found, span;
   logic [WORD_BITS-1:0]        avail, lo_mask, hi_mask, mask;
   logic [OFF_W-1:0]            free_bit;
   logic                        in_map, nonempty, full;

   // Page index to word index and bit offset.
   pba_div #(
      .NUM_W   (PG_W),
      .DIVISOR (WORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   // Map memory: one write and one registered read per cycle, both at word_ff.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[word_ff] <= mem_wdata;
      end
      rd_data_ff <= map_mem[word_ff];
   end

   // Values shared by the command setup and the scan.
   always_comb begin
      mp      = PG_W'(mem_pages_ff);
      dz      = PG_W'(dma_zone_ff);
      hz      = PG_W'(high_zone_ff);
      limit   = PG_W'(req_limit_page);
      page_x  = PG_W'(req_page);
      mem_end = (mp < PG_W'(PAGE_COUNT)) ? mp : PG_W'(PAGE_COUNT);
      in_map  = (page_x < PG_W'(PAGE_COUNT));

      // Preferred zone start and the first allocation window.
      if (mp > hz) begin
         ideal = hz;
      end else if (mp > dz) begin
         ideal = dz;
      end else begin
         ideal = '0;
      end
      a_start = ideal;
      a_lim   = mp;
      if (limit != '0) begin
         a_lim = limit;
         if (limit <= ideal) begin
            a_start = (limit <= dz) ? '0 : dz;
         end
      end

      range_end = page_x + PG_W'(req_count);
      if (range_end > mem_end) begin
         range_end = mem_end;
      end
      eff_end = (lim_ff < mem_end) ? lim_ff : mem_end;

      // Word evaluation terms.
      next_base = base_ff + PG_W'(WORD_BITS);
      avail     = ~rd_data_ff & (WORD_ONES << off_ff);
      free_bit  = lowest_set(avail);
      found     = base_ff + PG_W'(free_bit);
      span      = win_end_ff - base_ff;
      nonempty  = ((base_ff + PG_W'(off_ff)) < win_end_ff);
      full      = (win_end_ff >= next_base);
      lo_mask   = WORD_ONES << off_ff;
      hi_mask   = full ? WORD_ONES : ~(WORD_ONES << span[OFF_W:0]);
      mask      = nonempty ? (lo_mask & hi_mask) : '0;
   end

   // Command sequencer.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      used_in      = used_ff;
      start_in     = start_ff;
      lim_in       = lim_ff;
      win_end_in   = win_end_ff;
      base_in      = base_ff;
      word_in      = word_ff;
      off_in       = off_ff;
      first_in     = first_ff;
      was_in       = was_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_page_in  = rsp_page_ff;
      rsp_was_in   = rsp_was_ff;
      mem_we       = 1'b0;
      mem_wdata    = rd_data_ff;
      div_start    = 1'b0;
      div_num      = '0;

      case (state_ff)
         S_CLEAR: begin
            // Clearing pass: every page starts out used.
            mem_we    = 1'b1;
            mem_wdata = WORD_ONES;
            if (word_ff == MW_W'(MAP_WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (req_start) begin
               cmd_in  = req_cmd;
               used_in = req_used;
               if (req_cmd == pba_pkg::CMD_ALLOC) begin
                  start_in = a_start;
                  lim_in   = a_lim;
                  state_in = S_WIN;
               end else if (!in_map) begin
                  // A page beyond the map reads as used and is left alone.
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_page_in  = '0;
                  rsp_was_in   = 1'b1;
               end else begin
                  div_start  = 1'b1;
                  div_num    = page_x;
                  base_in    = page_x;
                  first_in   = 1'b1;
                  win_end_in = range_end;
                  state_in   = S_DIV;
               end
            end
         end

         S_WIN: begin
            // Open the current window unless it is empty.
            if (start_ff < eff_end) begin
               win_end_in = eff_end;
               div_start  = 1'b1;
               div_num    = start_ff;
               base_in    = start_ff;
               state_in   = S_DIV;
            end else begin
               state_in = S_NEXT;
            end
         end

         S_NEXT: begin
            // Fall back one zone lower, or give up after zone zero.
            if (start_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_page_in  = '0;
               rsp_was_in   = 1'b0;
               state_in     = S_IDLE;
            end else begin
               lim_in   = start_ff;
               start_in = (start_ff > dz) ? dz : '0;
               state_in = S_WIN;
            end
         end

         S_DIV: begin
            if (div_done) begin
               word_in  = div_quot[MW_W-1:0];
               off_in   = div_rem;
               base_in  = base_ff - PG_W'(div_rem);
               state_in = S_READ;
            end
         end

         S_READ: begin
            state_in = S_EVAL;
         end

         S_EVAL: begin
            case (cmd_ff)
               pba_pkg::CMD_ALLOC: begin
                  if (avail != '0) begin
                     if (found < win_end_ff) begin
                        mem_we       = 1'b1;
                        mem_wdata    = rd_data_ff | (WORD_ONE << free_bit);
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_page_in  = found[pba_pkg::PAGE_W-1:0];
                        rsp_was_in   = 1'b0;
                        state_in     = S_IDLE;
                     end else begin
                        state_in = S_NEXT;
                     end
                  end else if (next_base < win_end_ff) begin
                     base_in  = next_base;
                     word_in  = word_ff + 1'b1;
                     off_in   = '0;
                     state_in = S_READ;
                  end else begin
                     state_in = S_NEXT;
                  end
               end

               pba_pkg::CMD_MARK: begin
                  mem_we              = 1'b1;
                  mem_wdata           = rd_data_ff;
                  mem_wdata[off_ff]   = used_ff;
                  rsp_valid_in        = 1'b1;
                  rsp_ok_in           = 1'b1;
                  rsp_page_in         = '0;
                  rsp_was_in          = rd_data_ff[off_ff];
                  state_in            = S_IDLE;
               end

               pba_pkg::CMD_QUERY: begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in    = 1'b1;
                  rsp_page_in  = '0;
                  rsp_was_in   = rd_data_ff[off_ff];
                  state_in     = S_IDLE;
               end

               default: begin
                  // Range mark: set or clear the covered bits of this word.
                  mem_we    = 1'b1;
                  mem_wdata = used_ff ? (rd_data_ff | mask) : (rd_data_ff & ~mask);
                  first_in  = 1'b0;
                  if (first_ff) begin
                     was_in = rd_data_ff[off_ff];
                  end
                  if (nonempty && full && (next_base < win_end_ff)) begin
                     base_in  = next_base;
                     word_in  = word_ff + 1'b1;
                     off_in   = '0;
                     state_in = S_READ;
                  end else begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = 1'b1;
                     rsp_page_in  = '0;
                     rsp_was_in   = first_ff ? rd_data_ff[off_ff] : was_ff;
                     state_in     = S_IDLE;
                  end
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mem_pages_ff <= pba_pkg::RST_MEMORY_PAGES;
         dma_zone_ff  <= pba_pkg::RST_DMA_ZONE;
         high_zone_ff <= pba_pkg::RST_HIGH_ZONE;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               pba_pkg::REG_MEMORY_PAGES: mem_pages_ff <= csr_data;
               pba_pkg::REG_DMA_ZONE:     dma_zone_ff  <= csr_data;
               pba_pkg::REG_HIGH_ZONE:    high_zone_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Command and result payload.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      used_ff     <= used_in;
      start_ff    <= start_in;
      lim_ff      <= lim_in;
      win_end_ff  <= win_end_in;
      base_ff     <= base_in;
      off_ff      <= off_in;
      first_ff    <= first_in;
      was_ff      <= was_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_page_ff <= rsp_page_in;
      rsp_was_ff  <= rsp_was_in;
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_result_page = rsp_page_ff;
   assign rsp_was_used    = rsp_was_ff;

endmodule

### dv/tb_page_bitmap_allocator.sv
// Self-checking testbench for the page bitmap allocator with a bit-exact map predictor.
`timescale 1ns / 100ps

module tb_page_bitmap_allocator;

   localparam int unsigned PAGES     = pba_pkg::DEF_PAGE_COUNT;
   localparam int unsigned WB        = pba_pkg::DEF_WORD_BITS;
   localparam int unsigned MAP_WORDS = PAGES / WB;
   localparam logic [pba_pkg::CFG_W-1:0]     CFG_MAX   = '1;
   localparam logic [pba_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   // One pending job: either a command word or a register write.
   typedef struct packed {
      logic                          to_csr;
      logic [pba_pkg::CSR_IDX_W-1:0] reg_index;
      logic [pba_pkg::CFG_W-1:0]     reg_value;
      logic [pba_pkg::CMD_W-1:0]     cmd;
      logic [pba_pkg::PAGE_W-1:0]    page;
      logic [pba_pkg::CFG_W-1:0]     count;
      logic                          used;
      logic [pba_pkg::CFG_W-1:0]     limit_page;
   } map_job_type;

   // Expected contents of one result word.
   typedef struct packed {
      logic                       ok;
      logic [pba_pkg::PAGE_W-1:0] page;
      logic                       was_used;
   } map_answer_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_start = 1'b0;
   logic                          busy;
   logic [pba_pkg::CMD_W-1:0]     req_cmd = '0;
   logic [pba_pkg::PAGE_W-1:0]    req_page = '0;
   logic [pba_pkg::CFG_W-1:0]     req_count = '0;
   logic                          req_used = 1'b0;
   logic [pba_pkg::CFG_W-1:0]     req_limit_page = '0;
   logic                          rsp_valid;
   logic                          rsp_ok;
   logic [pba_pkg::PAGE_W-1:0]    rsp_result_page;
   logic                          rsp_was_used;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [pba_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pba_pkg::CFG_W-1:0]     csr_data = '0;

   map_job_type    cmd_backlog[$];
   map_answer_type answers_due[$];

   // Shadow copy of the used-bit map and the zone registers.
   logic [WB-1:0] shadow_map [MAP_WORDS];
   int unsigned   shadow_mem_pages;
   int unsigned   shadow_dma;
   int unsigned   shadow_high;

   // Zone layout that the stimulus builder is currently aiming at.
   int unsigned plan_mem;
   int unsigned plan_dma;
   int unsigned plan_high;

   int  in_flight = 0;
   int  issued = 0;
   int  fail_count = 0;
   logic drained = 1'b0;

   page_bitmap_allocator dut (
      .clock           (clock),
      .reset           (reset),
      .req_start       (req_start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_page        (req_page),
      .req_count       (req_count),
      .req_used        (req_used),
      .req_limit_page  (req_limit_page),
      .rsp_valid       (rsp_valid),
      .rsp_ok          (rsp_ok),
      .rsp_result_page (rsp_result_page),
      .rsp_was_used    (rsp_was_used),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Lowest free page in [lo, hi), scanning a word at a time.
   function automatic logic lowest_free(input int unsigned lo, input int unsigned hi,
                                        output int unsigned got);
      int unsigned   p;
      logic [WB-1:0] avail;
      logic          hit;
      logic          scanning;
      p = lo;
      hit = 1'b0;
      scanning = 1'b1;
      got = 0;
      while (scanning && p < hi) begin
         avail = ~shadow_map[p / WB] & ({WB{1'b1}} << (p % WB));
         if (avail == '0) begin
            p = (p / WB + 1) * WB;
         end else begin
            scanning = 1'b0;
            for (int x = WB - 1; x >= 0; x--)
               if (avail[x]) got = (p / WB) * WB + x;
            hit = (got < hi);
         end
      end
      return hit;
   endfunction

   // Allocation: preferred zone first, then one zone lower until zone zero fails.
   function automatic logic grab_lowest_free(input int unsigned limit, output int unsigned got);
      int unsigned mem_end;
      int unsigned ideal;
      int unsigned lo;
      int unsigned hi;
      logic        hit;
      logic        searching;
      mem_end = (shadow_mem_pages < PAGES) ? shadow_mem_pages : PAGES;
      if (shadow_mem_pages > shadow_high) ideal = shadow_high;
      else if (shadow_mem_pages > shadow_dma) ideal = shadow_dma;
      else ideal = 0;
      lo = ideal;
      hi = shadow_mem_pages;
      if (limit != 0) begin
         hi = limit;
         if (limit <= ideal) lo = (limit <= shadow_dma) ? 0 : shadow_dma;
      end
      hit = 1'b0;
      searching = 1'b1;
      got = 0;
      while (searching) begin
         hit = lowest_free(lo, (hi < mem_end) ? hi : mem_end, got);
         if (hit || lo == 0) begin
            searching = 1'b0;
         end else begin
            hi = lo;
            lo = (lo > shadow_dma) ? shadow_dma : 0;
         end
      end
      if (hit) shadow_map[got / WB][got % WB] = 1'b1;
      return hit;
   endfunction

   // Range mark, clipped to installed memory.
   function automatic void fill_range(input int unsigned first, input int unsigned count,
                                      input logic v);
      int unsigned lim;
      int unsigned stop;
      lim = (shadow_mem_pages < PAGES) ? shadow_mem_pages : PAGES;
      stop = first + count;
      if (stop > lim) stop = lim;
      for (int unsigned p = first; p < stop; p++)
         shadow_map[p / WB][p % WB] = v;
   endfunction

   // Applies one command word to the shadow map and returns the result it should give.
   function automatic map_answer_type predict_answer(input map_job_type j);
      map_answer_type a;
      int unsigned    got;
      a = '0;
      a.ok = 1'b1;
      if (j.cmd == pba_pkg::CMD_ALLOC) begin
         if (grab_lowest_free(32'(j.limit_page), got)) a.page = got[pba_pkg::PAGE_W-1:0];
         else a.ok = 1'b0;
      end else begin
         a.was_used = shadow_map[j.page / WB][j.page % WB];
         if (j.cmd == pba_pkg::CMD_MARK) shadow_map[j.page / WB][j.page % WB] = j.used;
         else if (j.cmd == pba_pkg::CMD_RANGE) fill_range(32'(j.page), 32'(j.count), j.used);
      end
      return a;
   endfunction

   // Page near one of the zone starts, or anywhere in the map now and then.
   function automatic logic [pba_pkg::PAGE_W-1:0] aim_page();
      int unsigned span;
      int unsigned p;
      span = (plan_mem < PAGES) ? plan_mem : PAGES;
      if (span == 0 || $urandom_range(0, 99) < 20) return pba_pkg::PAGE_W'($urandom);
      case ($urandom_range(0, 2))
         0:       p = 0;
         1:       p = plan_dma;
         default: p = plan_high;
      endcase
      p = p + $urandom_range(0, 383);
      if (p >= span) p = $urandom_range(0, span - 1);
      return p[pba_pkg::PAGE_W-1:0];
   endfunction

   task automatic add_cmd(input logic [pba_pkg::CMD_W-1:0] cmd,
                          input logic [pba_pkg::PAGE_W-1:0] page,
                          input logic [pba_pkg::CFG_W-1:0] count, input logic used,
                          input logic [pba_pkg::CFG_W-1:0] limit_page);
      map_job_type j;
      j = '0;
      j.cmd = cmd;
      j.page = page;
      j.count = count;
      j.used = used;
      j.limit_page = limit_page;
      cmd_backlog.push_back(j);
   endtask

   task automatic add_reg(input logic [pba_pkg::CSR_IDX_W-1:0] index,
                          input logic [pba_pkg::CFG_W-1:0] value);
      map_job_type j;
      j = '0;
      j.to_csr = 1'b1;
      j.reg_index = index;
      j.reg_value = value;
      cmd_backlog.push_back(j);
   endtask

   // Driver: issues command words with random gaps, none in a quiet stretch; register writes
   // wait until the block has gone idle with every result back.
   always @(posedge clock) begin
      map_job_type nxt;
      logic        cmd_done;
      logic        csr_done;
      logic        hold_cmd;
      logic        hold_csr;
      logic        quiet;
      if (reset) begin
         req_start <= 1'b0;
         csr_valid <= 1'b0;
         drained <= 1'b0;
         in_flight = 0;
      end else begin
         cmd_done = req_start && !busy;
         csr_done = csr_valid && csr_ready;
         in_flight = in_flight + (cmd_done ? 1 : 0) - (rsp_valid ? 1 : 0);
         hold_cmd = req_start && !cmd_done;
         hold_csr = csr_valid && !csr_done;
         quiet = (issued >= 300 && issued < 450);
         if (!hold_cmd && !hold_csr && cmd_backlog.size() != 0) begin
            if (cmd_backlog[0].to_csr) begin
               if (in_flight <= 0 && !busy) begin
                  nxt = cmd_backlog.pop_front();
                  csr_index <= nxt.reg_index;
                  csr_data <= nxt.reg_value;
                  hold_csr = 1'b1;
               end
            end else if (quiet || $urandom_range(0, 99) >= 14) begin
               nxt = cmd_backlog.pop_front();
               req_cmd <= nxt.cmd;
               req_page <= nxt.page;
               req_count <= nxt.count;
               req_used <= nxt.used;
               req_limit_page <= nxt.limit_page;
               hold_cmd = 1'b1;
               issued++;
            end
         end
         req_start <= hold_cmd;
         csr_valid <= hold_csr;
         drained <= !hold_cmd && !hold_csr && cmd_backlog.size() == 0 && in_flight <= 0;
      end
   end

   // Monitor: checks each result word, predicts for newly accepted words, tracks register writes.
   always @(posedge clock) begin
      map_job_type    j;
      map_answer_type want;
      if (reset) begin
         foreach (shadow_map[i]) shadow_map[i] = '1;
         shadow_mem_pages = 32'(pba_pkg::RST_MEMORY_PAGES);
         shadow_dma = 32'(pba_pkg::RST_DMA_ZONE);
         shadow_high = 32'(pba_pkg::RST_HIGH_ZONE);
      end else begin
         if (rsp_valid) begin
            if (answers_due.size() == 0) begin
               $error("result word with no command outstanding");
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_ok !== want.ok) begin
                  $error("ok: expected %0d, got %0d", want.ok, rsp_ok);
                  fail_count++;
               end
               if (rsp_result_page !== want.page) begin
                  $error("result_page: expected %0d, got %0d", want.page, rsp_result_page);
                  fail_count++;
               end
               if (rsp_was_used !== want.was_used) begin
                  $error("was_used: expected %0d, got %0d", want.was_used, rsp_was_used);
                  fail_count++;
               end
            end
         end
         if (req_start && !busy) begin
            j = '0;
            j.cmd = req_cmd;
            j.page = req_page;
            j.count = req_count;
            j.used = req_used;
            j.limit_page = req_limit_page;
            answers_due.push_back(predict_answer(j));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               pba_pkg::REG_MEMORY_PAGES: shadow_mem_pages = 32'(csr_data);
               pba_pkg::REG_DMA_ZONE:     shadow_dma = 32'(csr_data);
               pba_pkg::REG_HIGH_ZONE:    shadow_high = 32'(csr_data);
               default: ;
            endcase
         end
      end
   end

   // Stimulus build, reset, and the end of the run.
   initial begin
      int unsigned n_cmds;
      int unsigned roll;
      logic [pba_pkg::CMD_W-1:0] cmd;
      logic [pba_pkg::CFG_W-1:0] cnt;
      logic [pba_pkg::CFG_W-1:0] lim;

      // Directed part with the reset zones: a fully used map, window edges and clipping.
      add_cmd(pba_pkg::CMD_QUERY, 0, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_QUERY, pba_pkg::PAGE_W'(PAGES - 1), 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_RANGE, 4100, 130, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_MARK, 3, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 3000);
      add_cmd(pba_pkg::CMD_MARK, 3, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 4096);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 5000);
      add_cmd(pba_pkg::CMD_MARK, 5, 0, 1'b0, 0);
      // The window just above the DMA zone is full, so this falls back to zone zero.
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 4097);
      add_cmd(pba_pkg::CMD_RANGE, 10, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_RANGE, pba_pkg::PAGE_W'(PAGES - WB), CFG_MAX, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, CFG_MAX);
      add_cmd(pba_pkg::CMD_MARK, pba_pkg::PAGE_W'(PAGES - 1), 0, 1'b1, 0);
      add_cmd(pba_pkg::CMD_RANGE, 0, CFG_MAX, 1'b1, 0);
      add_cmd(pba_pkg::CMD_MARK, 0, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 1);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 1);

      // A high zone below installed memory: two-step and three-step fallback.
      add_reg(pba_pkg::REG_MEMORY_PAGES, pba_pkg::CFG_W'(PAGES));
      add_reg(pba_pkg::REG_DMA_ZONE, 4096);
      add_reg(pba_pkg::REG_HIGH_ZONE, 8192);
      add_cmd(pba_pkg::CMD_MARK, 100, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_MARK, 5000, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_MARK, 6000, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 8192);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 0);
      add_cmd(pba_pkg::CMD_ALLOC, 0, 0, 1'b0, 0);

      // Random phases. Most use a small memory so that scans stay short; a few use
      // the whole map, memory beyond the map, or no memory at all.
      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            2: begin
               plan_mem = CFG_MAX;
               plan_dma = CFG_MAX;
               plan_high = CFG_MAX;
               n_cmds = 30;
            end
            5: begin
               plan_mem = 0;
               plan_dma = 0;
               plan_high = 0;
               n_cmds = 20;
            end
            9: begin
               plan_mem = PAGES;
               plan_dma = $urandom_range(1, PAGES / 2);
               plan_high = $urandom_range(plan_dma, PAGES);
               n_cmds = 30;
            end
            default: begin
               plan_mem = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 4096);
               plan_dma = $urandom_range(0, plan_mem + 64);
               plan_high = $urandom_range(0, plan_mem + 64);
               n_cmds = 77;
            end
         endcase
         if (ph == 0) add_reg(REG_SPARE, pba_pkg::CFG_W'($urandom));
         add_reg(pba_pkg::REG_MEMORY_PAGES, pba_pkg::CFG_W'(plan_mem));
         add_reg(pba_pkg::REG_DMA_ZONE, pba_pkg::CFG_W'(plan_dma));
         add_reg(pba_pkg::REG_HIGH_ZONE, pba_pkg::CFG_W'(plan_high));
         repeat (n_cmds) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) cmd = pba_pkg::CMD_ALLOC;
            else if (roll < 55) cmd = pba_pkg::CMD_MARK;
            else if (roll < 70) cmd = pba_pkg::CMD_QUERY;
            else cmd = pba_pkg::CMD_RANGE;
            roll = $urandom_range(0, 99);
            if (roll < 5) cnt = '0;
            else if (roll < 10) cnt = pba_pkg::CFG_W'($urandom);
            else cnt = pba_pkg::CFG_W'($urandom_range(1, 200));
            roll = $urandom_range(0, 99);
            if (roll < 40) lim = '0;
            else if (roll < 55) lim = pba_pkg::CFG_W'($urandom);
            else lim = pba_pkg::CFG_W'(aim_page()) + pba_pkg::CFG_W'($urandom_range(0, 64));
            add_cmd(cmd, aim_page(), cnt, 1'($urandom_range(0, 1)), lim);
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      wait (drained);
      repeat (300) @(posedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d expected result words never arrived", answers_due.size());
         fail_count++;
      end
      if (fail_count == 0) $display("tb_page_bitmap_allocator: PASS");
      else $display("tb_page_bitmap_allocator: FAIL");
      $finish;
   end

   // Watchdog: several times the slowest correct run.
   initial begin
      #8_000_000;
      $display("tb_page_bitmap_allocator: FAIL");
      $finish;
   end

endmodule

### page_bitmap_allocator.f
hw/rtl/pba_pkg.sv
hw/rtl/pba_div.sv
hw/rtl/page_bitmap_allocator.sv
dv/tb_page_bitmap_allocator.sv
